// ===== src/nec_ir_pkg.sv =====
// nec ir decoder package: widths, register indexes, status codes, state types
// and the range compare used by nec_ir_decide
// no dependencies
package nec_ir_pkg;

  localparam int DUR_W     = 16;
  localparam int CODE_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 8;
  localparam int RNG_HALF  = 16;

  localparam int BUFFER_LEN_DEF    = 128;
  localparam int MIN_TAIL_DEF      = 66;
  localparam int DURATION_BITS_DEF = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_BITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SPACE  = 3'd7;

  localparam logic [CFG_W-1:0] SHORT_RST      = 32'd45875600;
  localparam logic [CFG_W-1:0] LONG_RST       = 32'd117966300;
  localparam logic [CFG_W-1:0] LEAD_MARK_RST  = 32'd622600500;
  localparam logic [CFG_W-1:0] LEAD_SPACE_RST = 32'd327684000;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 32'd163842000;
  localparam logic [CFG_W-1:0] PAUSE_RST      = 32'd2752550000;
  localparam logic [CFG_W-1:0] TAIL_SPACE_RST = 32'd163842000;

  typedef enum logic [1:0] {
    ST_ERROR  = 2'd0,
    ST_NEW    = 2'd1,
    ST_REPEAT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_SCAN   = 4'b0001,
    PH_LSPACE = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // tail sequence after the data bits
  localparam logic [1:0] TAIL_NONE  = 2'd0;
  localparam logic [1:0] TAIL_PAUSE = 2'd1;
  localparam logic [1:0] TAIL_LEAD  = 2'd2;
  localparam logic [1:0] TAIL_SPACE = 2'd3;

  typedef struct packed {
    logic              invert_bits;
    logic [CFG_W-1:0]  short_range;
    logic [CFG_W-1:0]  long_range;
    logic [CFG_W-1:0]  lead_mark_range;
    logic [CFG_W-1:0]  lead_space_range;
    logic [CFG_W-1:0]  repeat_range;
    logic [CFG_W-1:0]  pause_range;
    logic [CFG_W-1:0]  tail_space_range;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [POS_W-1:0]   position;
    logic               half_bit;
    logic [1:0]         tail_stage;
    logic [CODE_W-1:0]  shift_code;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    phase:      PH_SCAN,
    position:   '0,
    half_bit:   1'b0,
    tail_stage: TAIL_NONE,
    shift_code: '0
  };

  // minimum in the low half, maximum in the high half, both inclusive
  function automatic logic in_rng(input logic [DUR_W-1:0] d, input logic [CFG_W-1:0] r);
    return (d >= r[RNG_HALF-1:0]) && (d <= r[CFG_W-1:RNG_HALF]);
  endfunction

endpackage

// ===== src/nec_ir_if.sv =====
// item channels of the nec ir decoder: durations in, decode results out
// depends on nec_ir_pkg
interface nec_ir_in_if import nec_ir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;
  logic             frame_first;
  logic             frame_last;

  modport source (output valid, duration, frame_first, frame_last, input ready);
  modport sink   (input valid, duration, frame_first, frame_last, output ready);
endinterface

interface nec_ir_out_if import nec_ir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CODE_W-1:0] code;

  modport source (output valid, status, code, input ready);
  modport sink   (input valid, status, code, output ready);
endinterface

// ===== src/nec_ir_pulse_decoder_unit.sv =====
// Decodes NEC infrared frames from captured edge durations, one duration per
// item. Throughput is one item per clock unless a result waits on a stalled
// output; an item is held in the input register, then the range compares and
// frame-state update feed the result register. Each frame gives at most one
// result (error, new code or repeat); later items are dropped until the next
// frame_first. The user must write configuration registers through cfg_we/
// cfg_index/cfg_wdata only while no item is in flight, unchecked by the block.
// top level; depends on nec_ir_pkg, nec_ir_if, nec_ir_cfg_regs, nec_ir_decide
module nec_ir_pulse_decoder_unit import nec_ir_pkg::*; #(
  parameter int BUFFER_LEN    = BUFFER_LEN_DEF,
  parameter int MIN_TAIL      = MIN_TAIL_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nec_ir_in_if.sink            in_ch,
  nec_ir_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg;

  logic             stg_vld_r, stg_vld_nxt;
  logic [DUR_W-1:0] stg_dur_r;
  logic             stg_first_r;
  logic             stg_last_r;

  frame_state_t state_r, state_nxt;
  logic         res_fire;
  status_t      res_status;

  logic              out_vld_r, out_vld_nxt;
  status_t           out_status_r;
  logic [CODE_W-1:0] out_code_r;

  logic in_take;
  logic advance;

  nec_ir_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  nec_ir_decide #(
    .BUFFER_LEN    (BUFFER_LEN),
    .MIN_TAIL      (MIN_TAIL),
    .DURATION_BITS (DURATION_BITS)
  ) u_decide (
    .cfg      (cfg),
    .state_i  (state_r),
    .duration (stg_dur_r),
    .first    (stg_first_r),
    .last     (stg_last_r),
    .state_o  (state_nxt),
    .fire     (res_fire),
    .status   (res_status)
  );

  // an item without a result moves on even while the output is stalled
  assign advance = stg_vld_r && (!res_fire || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !stg_vld_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_take) begin
      stg_vld_nxt = 1'b1;
    end else if (advance) begin
      stg_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance && res_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= FRAME_CLEAR;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_dur_r   <= in_ch.duration;
      stg_first_r <= in_ch.frame_first;
      stg_last_r  <= in_ch.frame_last;
    end
    if (advance && res_fire) begin
      out_status_r <= res_status;
      out_code_r   <= state_nxt.shift_code;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.status = out_status_r;
  assign out_ch.code   = out_code_r;

`ifndef SYNTHESIS
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.phase == PH_DONE && !stg_first_r |-> !res_fire)
    else $error("result from a frame already decided");

  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_fire |=> state_r.phase == PH_DONE)
    else $error("frame not closed after its result");

  a_pos_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != PH_DONE |-> int'(state_r.position) < BUFFER_LEN)
    else $error("open frame past end of buffer");

  a_half_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.half_bit |-> state_r.phase == PH_DATA || state_r.phase == PH_DONE)
    else $error("half bit set outside data phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_code_r))
    else $error("pending result overwritten");
`endif

endmodule

// ===== src/nec_ir_cfg_regs.sv =====
// configuration registers of the nec ir decoder, written through a plain
// write port; depends on nec_ir_pkg
module nec_ir_cfg_regs import nec_ir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [CFG_IDX_W-1:0] idx,
  input  logic [CFG_W-1:0]     wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (idx)
        CFG_INVERT_BITS: cfg_nxt.invert_bits      = wdata[0];
        CFG_SHORT:       cfg_nxt.short_range      = wdata;
        CFG_LONG:        cfg_nxt.long_range       = wdata;
        CFG_LEAD_MARK:   cfg_nxt.lead_mark_range  = wdata;
        CFG_LEAD_SPACE:  cfg_nxt.lead_space_range = wdata;
        CFG_REPEAT:      cfg_nxt.repeat_range     = wdata;
        CFG_PAUSE:       cfg_nxt.pause_range      = wdata;
        CFG_TAIL_SPACE:  cfg_nxt.tail_space_range = wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_bits      <= 1'b0;
      cfg_r.short_range      <= SHORT_RST;
      cfg_r.long_range       <= LONG_RST;
      cfg_r.lead_mark_range  <= LEAD_MARK_RST;
      cfg_r.lead_space_range <= LEAD_SPACE_RST;
      cfg_r.repeat_range     <= REPEAT_RST;
      cfg_r.pause_range      <= PAUSE_RST;
      cfg_r.tail_space_range <= TAIL_SPACE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/nec_ir_decide.sv =====
// per-duration decision logic of the nec ir decoder: next frame state and
// the result of one item; depends on nec_ir_pkg
module nec_ir_decide import nec_ir_pkg::*; #(
  parameter int BUFFER_LEN    = BUFFER_LEN_DEF,
  parameter int MIN_TAIL      = MIN_TAIL_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  cfg_t             cfg,
  input  frame_state_t     state_i,
  input  logic [DUR_W-1:0] duration,
  input  logic             first,
  input  logic             last,
  output frame_state_t     state_o,
  output logic             fire,
  output status_t          status
);

  localparam int DUSE = (DURATION_BITS < DUR_W) ? DURATION_BITS : DUR_W;
  localparam logic [DUR_W-1:0] DMASK = DUR_W'((64'(1) << DUSE) - 64'(1));
  localparam int LATE_MAX = BUFFER_LEN - MIN_TAIL;

  frame_state_t     cur;
  frame_state_t     nxt;
  logic [DUR_W-1:0] d;
  logic             dec;
  logic             late;
  logic             buf_end;
  status_t          stat;

  assign d = duration & DMASK;

  always_comb begin
    cur = first ? FRAME_CLEAR : state_i;
    nxt = cur;
    dec = 1'b0;
    stat = ST_ERROR;
    // lead mark leaves too few slots behind it
    late = int'({1'b0, cur.position}) > LATE_MAX;
    buf_end = ({1'b0, cur.position} + (POS_W+1)'(1)) >= (POS_W+1)'(BUFFER_LEN);

    unique case (cur.phase)
      PH_SCAN: begin
        if (in_rng(d, cfg.repeat_range)) begin
          dec = 1'b1;
          stat = ST_REPEAT;
        end else if (in_rng(d, cfg.lead_mark_range)) begin
          if (late) begin
            dec = 1'b1;
          end else begin
            nxt.phase = PH_LSPACE;
          end
        end
      end
      PH_LSPACE: begin
        if (!in_rng(d, cfg.lead_space_range)) begin
          dec = 1'b1;
        end else begin
          nxt.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        priority if (in_rng(d, cfg.short_range)) begin
          if (cur.tail_stage == TAIL_SPACE) begin
            dec = 1'b1;
            stat = ST_NEW;
          end else if (!cur.half_bit) begin
            nxt.half_bit = 1'b1;
          end else begin
            nxt.half_bit = 1'b0;
            nxt.shift_code = {cur.shift_code[CODE_W-2:0], ~cfg.invert_bits};
          end
        end else if (in_rng(d, cfg.long_range)) begin
          if (!cur.half_bit) begin
            dec = 1'b1;
          end else begin
            nxt.half_bit = 1'b0;
            nxt.shift_code = {cur.shift_code[CODE_W-2:0], cfg.invert_bits};
          end
        end else if (d == '0 && cur.half_bit) begin
          // empty slot after a short closes the frame
          dec = 1'b1;
          stat = ST_NEW;
        end else if (in_rng(d, cfg.pause_range)) begin
          nxt.tail_stage = TAIL_PAUSE;
        end else if (cur.tail_stage == TAIL_PAUSE && in_rng(d, cfg.lead_mark_range)) begin
          nxt.tail_stage = TAIL_LEAD;
        end else if (cur.tail_stage == TAIL_LEAD && in_rng(d, cfg.tail_space_range)) begin
          nxt.tail_stage = TAIL_SPACE;
        end else if (in_rng(d, cfg.repeat_range)) begin
          dec = 1'b1;
          stat = ST_REPEAT;
        end else begin
          dec = 1'b1;
        end
      end
      PH_DONE: begin
        dec = 1'b0;
      end
      default: begin
        dec = 1'b0;
      end
    endcase

    if (cur.phase != PH_DONE) begin
      if (!dec && (buf_end || last)) begin
        dec = 1'b1;
        stat = ST_ERROR;
      end
      nxt.position = cur.position + POS_W'(1);
      if (dec) begin
        nxt.phase = PH_DONE;
      end
    end
  end

  assign state_o = nxt;
  assign fire    = dec;
  assign status  = stat;

endmodule

// ===== dv/tb_nec_ir_pulse_decoder_unit.sv =====
// testbench for nec_ir_pulse_decoder_unit: a directed table of frames, then random
// frames under several register settings, checked by table rows or a built-in model
// depends on nec_ir_pkg, nec_ir_if and the decoder rtl
module tb_nec_ir_pulse_decoder_unit;
  import nec_ir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    status_t           status;
    logic [CODE_W-1:0] code;
  } decode_result_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             first;
    logic             last;
  } ir_item_t;

  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic              first;
    logic              last;
    int                reps;
    logic              typed;
    status_t           status;
    logic [CODE_W-1:0] code;
  } directed_row_t;

  // default timing: short 400..700, long 1500..1800, lead 8500..9500,
  // lead space 4000..5000, repeat and tail space 2000..2500, pause 38000..42000
  localparam directed_row_t DIRECTED_ROWS [41] = '{
    '{16'd2200,  1'b1, 1'b0, 1,   1'b1, ST_REPEAT, 32'd0},  // repeat while scanning
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // dropped, frame done
    '{16'd0,     1'b1, 1'b1, 1,   1'b1, ST_ERROR,  32'd0},
    '{16'd65535, 1'b1, 1'b1, 1,   1'b1, ST_ERROR,  32'd0},
    '{16'd9000,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd4500,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd400,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd700,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd1800,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd0,     1'b0, 1'b0, 1,   1'b1, ST_NEW,    32'd2},  // empty slot after a short
    '{16'd8500,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd3999,  1'b0, 1'b0, 1,   1'b1, ST_ERROR,  32'd0},  // bad lead space
    '{16'd9500,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd5000,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd1500,  1'b0, 1'b0, 1,   1'b1, ST_ERROR,  32'd0},  // long with no short before
    '{16'd9000,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd4000,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 2,   1'b0, ST_ERROR,  32'd0},
    '{16'd38000, 1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // pause, lead, tail space
    '{16'd9000,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd2000,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // short after the tail
    '{16'd9000,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // frame left undecided
    '{16'd4500,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd9000,  1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd4500,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd500,   1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd2500,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // repeat inside the data
    '{16'd100,   1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd100,   1'b0, 1'b0, 62,  1'b0, ST_ERROR,  32'd0},
    '{16'd9000,  1'b0, 1'b0, 1,   1'b1, ST_ERROR,  32'd0},  // lead one slot too late
    '{16'd100,   1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd100,   1'b0, 1'b0, 61,  1'b0, ST_ERROR,  32'd0},
    '{16'd9000,  1'b0, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},  // latest lead allowed
    '{16'd4500,  1'b0, 1'b1, 1,   1'b1, ST_ERROR,  32'd0},  // frame ends early
    '{16'd100,   1'b1, 1'b0, 1,   1'b0, ST_ERROR,  32'd0},
    '{16'd100,   1'b0, 1'b0, 127, 1'b1, ST_ERROR,  32'd0},  // runs off the buffer end
    '{16'd500,   1'b0, 1'b1, 1,   1'b0, ST_ERROR,  32'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nec_ir_in_if  in_ch ();
  nec_ir_out_if out_ch ();

  nec_ir_pulse_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // decoder model state and its copy of the registers
  cfg_t              shadow_cfg;
  phase_t            dec_phase;
  logic [POS_W-1:0]  dec_pos;
  logic              dec_half;
  logic [1:0]        dec_tail;
  logic [CODE_W-1:0] dec_code;

  decode_result_t awaited_decodes [$];
  int             error_count;
  int             sent_items;
  int             idle_cycles;
  int             gap_odds;
  bit             sender_gaps;
  bit             receiver_gaps;
  bit             hold_off_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit dur_in_window(input logic [DUR_W-1:0] d, input logic [CFG_W-1:0] r);
    return (d >= r[RNG_HALF-1:0]) && (d <= r[CFG_W-1:RNG_HALF]);
  endfunction

  function automatic logic [CFG_W-1:0] mk_window(input int lo, input int hi);
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic cfg_t reset_cfg();
    return '{invert_bits: 1'b0, short_range: SHORT_RST, long_range: LONG_RST,
             lead_mark_range: LEAD_MARK_RST, lead_space_range: LEAD_SPACE_RST,
             repeat_range: REPEAT_RST, pause_range: PAUSE_RST,
             tail_space_range: TAIL_SPACE_RST};
  endfunction

  function automatic logic [CFG_W-1:0] random_window();
    int lo;
    int hi;
    lo = $urandom_range(65535, 0);
    hi = lo + $urandom_range(3000, 0);
    if (hi > 65535) hi = 65535;
    if ($urandom_range(4, 0) == 0) return $urandom;
    return mk_window(lo, hi);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.invert_bits      = 1'($urandom_range(1, 0));
    c.short_range      = random_window();
    c.long_range       = random_window();
    c.lead_mark_range  = random_window();
    c.lead_space_range = random_window();
    c.repeat_range     = random_window();
    c.pause_range      = random_window();
    c.tail_space_range = random_window();
    return c;
  endfunction

  function automatic void clear_decoder();
    dec_phase = PH_SCAN;
    dec_pos   = '0;
    dec_half  = 1'b0;
    dec_tail  = TAIL_NONE;
    dec_code  = '0;
  endfunction

  // one duration through the decoder model; returns 1 when it closes the frame
  function automatic bit decode_duration(input logic [DUR_W-1:0] d, input logic first,
                                         input logic last, output decode_result_t res);
    bit      decided;
    status_t verdict;
    decided = 1'b0;
    verdict = ST_ERROR;
    res = '0;
    if (first) clear_decoder();
    if (dec_phase == PH_DONE) return 1'b0;
    case (dec_phase)
      PH_SCAN: begin
        if (dur_in_window(d, shadow_cfg.repeat_range)) begin
          decided = 1'b1;
          verdict = ST_REPEAT;
        end else if (dur_in_window(d, shadow_cfg.lead_mark_range)) begin
          if (BUFFER_LEN_DEF - int'(dec_pos) < MIN_TAIL_DEF) decided = 1'b1;
          else dec_phase = PH_LSPACE;
        end
      end
      PH_LSPACE: begin
        if (!dur_in_window(d, shadow_cfg.lead_space_range)) decided = 1'b1;
        else dec_phase = PH_DATA;
      end
      default: begin
        if (dur_in_window(d, shadow_cfg.short_range)) begin
          if (dec_tail == TAIL_SPACE) begin
            decided = 1'b1;
            verdict = ST_NEW;
          end else if (!dec_half) begin
            dec_half = 1'b1;
          end else begin
            dec_half = 1'b0;
            dec_code = {dec_code[CODE_W-2:0], ~shadow_cfg.invert_bits};
          end
        end else if (dur_in_window(d, shadow_cfg.long_range)) begin
          if (!dec_half) begin
            decided = 1'b1;
          end else begin
            dec_code = {dec_code[CODE_W-2:0], shadow_cfg.invert_bits};
            dec_half = 1'b0;
          end
        end else if (d == '0 && dec_half) begin
          decided = 1'b1;
          verdict = ST_NEW;
        end else if (dur_in_window(d, shadow_cfg.pause_range)) begin
          dec_tail = TAIL_PAUSE;
        end else if (dec_tail == TAIL_PAUSE && dur_in_window(d, shadow_cfg.lead_mark_range)) begin
          dec_tail = TAIL_LEAD;
        end else if (dec_tail == TAIL_LEAD && dur_in_window(d, shadow_cfg.tail_space_range)) begin
          dec_tail = TAIL_SPACE;
        end else if (dur_in_window(d, shadow_cfg.repeat_range)) begin
          decided = 1'b1;
          verdict = ST_REPEAT;
        end else begin
          decided = 1'b1;
        end
      end
    endcase
    // buffer end or frame_last without a decision
    if (!decided && (int'(dec_pos) + 1 >= BUFFER_LEN_DEF || last)) begin
      decided = 1'b1;
      verdict = ST_ERROR;
    end
    dec_pos = dec_pos + 1'b1;
    if (!decided) return 1'b0;
    dec_phase  = PH_DONE;
    res.status = verdict;
    res.code   = dec_code;
    return 1'b1;
  endfunction

  function automatic logic [DUR_W-1:0] pick_in(input logic [CFG_W-1:0] r);
    logic [DUR_W-1:0] lo;
    logic [DUR_W-1:0] hi;
    lo = r[RNG_HALF-1:0];
    hi = r[CFG_W-1:RNG_HALF];
    if (lo > hi) return DUR_W'($urandom_range(65535, 0));
    case ($urandom_range(3, 0))
      0: return lo;
      1: return hi;
      default: return DUR_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic ir_item_t plain(input logic [DUR_W-1:0] d);
    return '{dur: d, first: 1'b0, last: 1'b0};
  endfunction

  task automatic flag_decode_error(input string msg);
    $display("[%0t] decode mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // drive one item, wait for the handshake, then run it through the model
  task automatic send_item(input logic [DUR_W-1:0] d, input logic first, input logic last,
                           input bit typed, input decode_result_t typed_res);
    decode_result_t res;
    bit             got;
    if (sender_gaps && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.duration    <= d;
    in_ch.frame_first <= first;
    in_ch.frame_last  <= last;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sent_items++;
    got = decode_duration(d, first, last, res);
    if (typed) awaited_decodes.push_back(typed_res);
    else if (got) awaited_decodes.push_back(res);
  endtask

  // input idle, every result back, then let the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_INVERT_BITS, {{(CFG_W-1){1'b0}}, c.invert_bits});
    write_reg(CFG_SHORT, c.short_range);
    write_reg(CFG_LONG, c.long_range);
    write_reg(CFG_LEAD_MARK, c.lead_mark_range);
    write_reg(CFG_LEAD_SPACE, c.lead_space_range);
    write_reg(CFG_REPEAT, c.repeat_range);
    write_reg(CFG_PAUSE, c.pause_range);
    write_reg(CFG_TAIL_SPACE, c.tail_space_range);
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  task automatic play_frame(input bit short_only);
    ir_item_t frm [$];
    int       kind;
    int       prefix;
    int       nbits;
    int       idx;
    case ($urandom_range(2, 0))
      0: gap_odds = 0;
      1: gap_odds = 8;
      default: gap_odds = 3;
    endcase
    kind = short_only ? $urandom_range(34, 0) : $urandom_range(99, 0);
    if (kind < 15) begin
      // loose noise with frame marks at random
      repeat ($urandom_range(12, 1))
        frm.push_back('{dur: DUR_W'($urandom), first: ($urandom_range(3, 0) == 0),
                        last: ($urandom_range(7, 0) == 0)});
    end else if (kind < 35) begin
      repeat ($urandom_range(2, 0)) frm.push_back(plain(DUR_W'($urandom)));
      if ($urandom_range(3, 0) == 0) frm.push_back(plain(pick_in(shadow_cfg.lead_mark_range)));
      frm.push_back(plain(pick_in(shadow_cfg.repeat_range)));
    end else begin
      prefix = ($urandom_range(19, 0) == 0) ? $urandom_range(66, 56) : $urandom_range(3, 0);
      repeat (prefix) frm.push_back(plain(DUR_W'($urandom)));
      frm.push_back(plain(pick_in(shadow_cfg.lead_mark_range)));
      frm.push_back(plain(pick_in(shadow_cfg.lead_space_range)));
      nbits = ($urandom_range(4, 0) < 3) ? 32 : $urandom_range(40, 0);
      repeat (nbits) begin
        frm.push_back(plain(pick_in(shadow_cfg.short_range)));
        frm.push_back(plain($urandom_range(1, 0) ? pick_in(shadow_cfg.short_range)
                                                 : pick_in(shadow_cfg.long_range)));
      end
      case ($urandom_range(11, 0))
        0, 1, 2: begin
          frm.push_back(plain(pick_in(shadow_cfg.short_range)));
          frm.push_back(plain('0));
        end
        3, 4, 5: begin
          frm.push_back(plain(pick_in(shadow_cfg.pause_range)));
          frm.push_back(plain(pick_in(shadow_cfg.lead_mark_range)));
          frm.push_back(plain(pick_in(shadow_cfg.tail_space_range)));
          frm.push_back(plain(pick_in(shadow_cfg.short_range)));
        end
        6, 7: begin
          frm.push_back(plain(pick_in(shadow_cfg.short_range)));
          frm[$].last = 1'b1;
        end
        8: frm.push_back(plain(pick_in(shadow_cfg.repeat_range)));
        9: while (frm.size() < BUFFER_LEN_DEF + 1)
             frm.push_back(plain(pick_in(shadow_cfg.short_range)));
        default: frm.push_back(plain(DUR_W'($urandom)));
      endcase
      if ($urandom_range(4, 0) == 0) begin
        // one slot spoiled, often just outside the short window
        idx = $urandom_range(frm.size() - 1, 1);
        case ($urandom_range(2, 0))
          0: frm[idx].dur = shadow_cfg.short_range[RNG_HALF-1:0] - 1'b1;
          1: frm[idx].dur = shadow_cfg.short_range[CFG_W-1:RNG_HALF] + 1'b1;
          default: frm[idx].dur = DUR_W'($urandom);
        endcase
      end
    end
    if (kind >= 15) begin
      frm[0].first = 1'b1;
      if ($urandom_range(2, 0) == 0)
        repeat ($urandom_range(3, 1)) frm.push_back(plain(DUR_W'($urandom)));
      if ($urandom_range(9, 0) == 0) frm[$].last = 1'b1;
    end
    foreach (frm[i]) send_item(frm[i].dur, frm[i].first, frm[i].last, 1'b0, '0);
  endtask

  task automatic run_frames(input int target, input bit short_only);
    int start;
    start = sent_items;
    while (sent_items - start < target) play_frame(short_only);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ch.ready <= 1'b0;
        n = HOLD_OFF_CYCLES;
      end else if (receiver_gaps && $urandom_range(3, 0) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(17, 1);
      end else begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(40, 1);
      end
      repeat (n) @(posedge clk);
    end
  end

  // results and watchdog, sampled mid-cycle where everything is settled
  always @(negedge clk) begin
    decode_result_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_decodes.size() == 0) begin
          flag_decode_error($sformatf("unexpected result status %0d code %08h",
                                      out_ch.status, out_ch.code));
        end else begin
          want = awaited_decodes.pop_front();
          if (out_ch.status !== want.status)
            flag_decode_error($sformatf("status %0d, want %0d", out_ch.status, want.status));
          if (out_ch.code !== want.code)
            flag_decode_error($sformatf("code %08h, want %08h", out_ch.code, want.code));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    decode_result_t typed_res;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.duration    <= '0;
    in_ch.frame_first <= 1'b0;
    in_ch.frame_last  <= 1'b0;
    error_count      = 0;
    sent_items       = 0;
    idle_cycles      = 0;
    gap_odds         = 4;
    sender_gaps      = 1'b1;
    receiver_gaps    = 1'b1;
    hold_off_pending = 1'b0;
    shadow_cfg = reset_cfg();
    clear_decoder();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      typed_res = '{status: DIRECTED_ROWS[i].status, code: DIRECTED_ROWS[i].code};
      for (int k = 0; k < DIRECTED_ROWS[i].reps; k++)
        send_item(DIRECTED_ROWS[i].dur, DIRECTED_ROWS[i].first && k == 0,
                  DIRECTED_ROWS[i].last && k == DIRECTED_ROWS[i].reps - 1,
                  DIRECTED_ROWS[i].typed && k == DIRECTED_ROWS[i].reps - 1, typed_res);
    end

    // inverted bits; short frames first so results pile up during the hold-off
    settle();
    c = reset_cfg();
    c.invert_bits = 1'b1;
    load_config(c);
    hold_off_pending = 1'b1;
    run_frames(40, 1'b1);
    run_frames(100, 1'b0);

    settle();
    load_config('{invert_bits: 1'b0, short_range: mk_window(200, 350),
                  long_range: mk_window(800, 1000), lead_mark_range: mk_window(3000, 3500),
                  lead_space_range: mk_window(1500, 1800), repeat_range: mk_window(1100, 1300),
                  pause_range: mk_window(20000, 30000), tail_space_range: mk_window(1100, 1300)});
    run_frames(120, 1'b0);

    // every window at 65535 only, then every window down to zero only
    settle();
    load_config('{invert_bits: 1'b1, short_range: '1, long_range: '1, lead_mark_range: '1,
                  lead_space_range: '1, repeat_range: '1, pause_range: '1,
                  tail_space_range: '1});
    run_frames(40, 1'b0);
    settle();
    load_config('0);
    run_frames(40, 1'b0);

    repeat (2) begin
      settle();
      load_config(random_cfg());
      run_frames(60, 1'b0);
    end

    // back to defaults at full rate
    settle();
    load_config(reset_cfg());
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    run_frames(120, 1'b0);

    settle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
